/* hw/rtl/sha256_pkg.sv */
// shared constants, types and round functions for the sha-256 hasher
package sha256_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned ChainN   = 8;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_word(input logic mode, input logic [2:0] i);
    word_t v;
    case ({mode, i})
      4'd0: v = 32'h6a09e667; 4'd1: v = 32'hbb67ae85; 4'd2: v = 32'h3c6ef372;
      4'd3: v = 32'ha54ff53a; 4'd4: v = 32'h510e527f; 4'd5: v = 32'h9b05688c;
      4'd6: v = 32'h1f83d9ab; 4'd7: v = 32'h5be0cd19; 4'd8: v = 32'hc1059ed8;
      4'd9: v = 32'h367cd507; 4'd10: v = 32'h3070dd17; 4'd11: v = 32'hf70e5939;
      4'd12: v = 32'hffc00b31; 4'd13: v = 32'h68581511; 4'd14: v = 32'h64f98fa7;
      default: v = 32'hbefa4fa4;
    endcase
    return v;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* hw/rtl/sha256_ram.sv */
// generic single-write ram with one registered read port
module sha256_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/sha256_message_hasher_core.sv */
// sha-256 / sha-224 hasher top level with block buffer and round engine
//
// usage: the message arrives on the input channel as big-endian 32-bit words
// (data_word_i, byte_count_i valid bytes from the top, last_item_i on the
// final word). a request is taken when in_valid_i is high and in_stall_o low.
// bytes pack into a 16-word block memory; a full block starts compression.
// digest words leave on the output channel, first word first, with
// digest_last_o on the final one (word 8 for sha-256, word 7 for sha-224).
// a word is accepted, then merged into its block word, with a second merge
// when it straddles two block words; a full block holds the input during
// the load, 64 rounds and the chaining add; sustained throughput is bound
// by the single round unit and the single read port of the block ram.
// after the last word, padding fills the rest of the block and runs it,
// plus a second block when the length does not fit.
// reset selects sha-256 with its initial values and an empty message.
// while the receiver stalls, the held digest word stays and no new input
// is accepted until the digest has been fully delivered.
// writing the mode while no message is open also reloads the chain.
module sha256_message_hasher_core
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);
  localparam int unsigned Blk = BlkWords;
  localparam int unsigned AW  = $clog2(Blk);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,  // waiting for a word
    ST_RMW   = 7'b000_0010,  // byte merge into the block word
    ST_PAD   = 7'b000_0100,  // padding fill
    ST_RD    = 7'b000_1000,  // prime first block read
    ST_ROUND = 7'b001_0000,
    ST_ADD   = 7'b010_0000,
    ST_OUT   = 7'b100_0000
  } state_e;

  state_e      state_q;
  logic        mode_q;
  logic [63:0] total_q;
  word_t       chain_q [ChainN];
  word_t       win_q [Blk];
  word_t       a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [5:0]  t_q;
  logic [3:0]  oidx_q;
  logic        fin_q;       // padding in progress
  logic        len_q;       // pad byte already placed
  logic        padtwo_q;    // second padding block needed
  logic [AW-1:0] padidx_q;
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [2:0]  done_q;      // bytes already merged from word_q

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  word_t         ram_wdata, ram_rdata;

  sha256_ram #(.Width(WordW), .Depth(Blk)) u_blk (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  logic [5:0]  pos;
  logic [1:0]  bpos;
  assign pos  = total_q[5:0];
  assign bpos = total_q[1:0];

  // bytes of the current word still to merge into this block word
  logic [2:0] remain, take, room;
  assign remain = cnt_q - done_q;
  assign room   = 3'd4 - {1'b0, bpos};
  assign take   = (remain < room) ? remain : room;

  // byte position after this merge
  logic [5:0] pos_nx;
  assign pos_nx = pos + 6'(take);

  // merged word: keep bytes above bpos from ram, new bytes next, rest zero
  word_t src_sh, merged, keepmask, newmask;
  always_comb begin
    src_sh   = word_q << {done_q[1:0], 3'b000};
    src_sh   = src_sh >> {bpos, 3'b000};
    keepmask = (bpos == 2'd0) ? 32'h0 : ~(32'hffff_ffff >> {bpos, 3'b000});
    newmask  = ~(32'hffff_ffff >> {take[2:0], 3'b000});
    if (take == 3'd4) newmask = 32'hffff_ffff;
    newmask  = newmask >> {bpos, 3'b000};
    merged   = (ram_rdata & keepmask) | (src_sh & newmask);
  end

  // padding word for the 0x80 position
  word_t padword;
  assign padword = (ram_rdata & keepmask) | (32'h8000_0000 >> {bpos, 3'b000});

  // round datapath
  word_t w_new, w_use, t1, t2;
  always_comb begin
    w_new = ssig1(win_q[Blk-2]) + win_q[Blk-7] + ssig0(win_q[1]) + win_q[0];
    w_use = (t_q < 6'd16) ? ram_rdata : w_new;
    t1 = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + round_k(t_q) + w_use;
    t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
  end

  logic [63:0] bits;
  assign bits = {total_q[60:0], 3'b000};

  logic [3:0] nout;
  assign nout = mode_q ? 4'd7 : 4'd8;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[5:2];
    ram_wdata = merged;
    ram_raddr = pos[5:2];
    case (state_q)
      ST_IDLE: ram_raddr = pos[5:2];
      ST_RMW: begin
        ram_we = (take != 3'd0);
        ram_raddr = pos_nx[5:2];
      end
      ST_PAD: begin
        ram_we = 1'b1;
        ram_waddr = padidx_q;
        if (!len_q) begin
          ram_wdata = padword;
        end else if (!padtwo_q && padidx_q == AW'(Blk-2)) begin
          ram_wdata = bits[63:32];
        end else if (!padtwo_q && padidx_q == AW'(Blk-1)) begin
          ram_wdata = bits[31:0];
        end else begin
          ram_wdata = '0;
        end
        ram_raddr = '0;
      end
      ST_RD: ram_raddr = '0;
      ST_ROUND: ram_raddr = AW'(t_q[3:0] + 4'd1);
      default: ;
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[oidx_q[2:0]];
  assign digest_last_o = (oidx_q + 4'd1 == nout);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= 1'b0;
      total_q  <= '0;
      t_q      <= '0;
      oidx_q   <= '0;
      fin_q    <= 1'b0;
      len_q    <= 1'b0;
      padtwo_q <= 1'b0;
      padidx_q <= '0;
      done_q   <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      for (int i = 0; i < ChainN; i++) chain_q[i] <= init_word(1'b0, 3'(i));
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
        if (total_q == '0) begin
          for (int i = 0; i < ChainN; i++) chain_q[i] <= init_word(cfg_wdata_i, 3'(i));
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            word_q <= data_word_i;
            cnt_q  <= (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
            last_q <= last_item_i;
            done_q <= '0;
            state_q <= ST_RMW;
          end
        end
        ST_RMW: begin
          // ram_rdata holds block word at pos[5:2]
          if (take == 3'd0) begin
            if (last_q) begin
              fin_q <= 1'b1;
              len_q <= 1'b0;
              padidx_q <= pos[5:2];
              padtwo_q <= (pos[5:2] >= AW'(Blk-2));
              state_q <= ST_PAD;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            total_q <= total_q + 64'(take);
            done_q  <= done_q + take;
            if (pos_nx == 6'd0) begin
              state_q <= ST_RD;
            end else begin
              state_q <= ST_IDLE;
              if (done_q + take != cnt_q || last_q) state_q <= ST_RMW;
            end
          end
        end
        ST_PAD: begin
          padidx_q <= padidx_q + AW'(1);
          len_q    <= 1'b1;
          if (padidx_q == AW'(Blk-1)) state_q <= ST_RD;
        end
        ST_RD: begin
          a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
          e_q <= chain_q[4]; f_q <= chain_q[5]; g_q <= chain_q[6]; h_q <= chain_q[7];
          t_q <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < Blk-1; i++) win_q[i] <= win_q[i+1];
          win_q[Blk-1] <= w_use;
          h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
          d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
          t_q <= t_q + 6'd1;
          if (t_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q; chain_q[5] <= chain_q[5] + f_q;
          chain_q[6] <= chain_q[6] + g_q; chain_q[7] <= chain_q[7] + h_q;
          if (!fin_q) begin
            // block filled by data: continue the word or finish
            state_q <= (done_q != cnt_q || last_q) ? ST_RMW : ST_IDLE;
          end else if (padtwo_q) begin
            padtwo_q <= 1'b0;
            padidx_q <= '0;
            len_q    <= 1'b1;
            state_q  <= ST_PAD;
          end else begin
            oidx_q  <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            oidx_q <= oidx_q + 4'd1;
            if (digest_last_o) begin
              fin_q   <= 1'b0;
              total_q <= '0;
              state_q <= ST_IDLE;
              for (int i = 0; i < ChainN; i++) chain_q[i] <= init_word(mode_q, 3'(i));
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

/* tb/tb.sv */
// self-checking testbench for the sha-256 / sha-224 message hasher core
`timescale 1ns / 1ps

module tb
  import sha256_pkg::*;
();

  typedef struct packed {
    word_t word;
    logic  last;
  } digest_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 200;
  localparam logic ModeSha256 = 1'b0;
  localparam logic ModeSha224 = 1'b1;

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam word_t IvSha256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam word_t IvSha224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] data_word_i;
  logic [2:0]  byte_count_i;
  logic        last_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic        digest_last_o;

  sha256_message_hasher_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .digest_last_o(digest_last_o)
  );

  // hash model state
  logic        hash_mode;
  word_t       chain [8];
  word_t       msg_block [16];
  logic [63:0] msg_bytes;

  digest_t digest_q [$];
  int      mismatches = 0;
  int      items_sent;
  int      cycles = 0;
  bit      calm = 1'b0;
  int      long_holds = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void load_iv();
    for (int i = 0; i < 8; i++) chain[i] = hash_mode ? IvSha224[i] : IvSha256[i];
  endfunction

  function automatic void compress();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = msg_block[t];
    for (int t = 16; t < 64; t++) begin
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function automatic void absorb_byte(logic [7:0] v);
    int pos;
    pos = int'(msg_bytes[5:0]);
    msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
    msg_bytes++;
    if (msg_bytes[5:0] == 6'd0) compress();
  endfunction

  // pad, finish and queue the digest words
  function automatic void finish_digest();
    int pos;
    int idx;
    logic [63:0] bits;
    pos = int'(msg_bytes[5:0]);
    idx = pos / 4;
    bits = msg_bytes << 3;
    for (int k = pos % 4; k < 4; k++) msg_block[idx][(3 - k) * 8 +: 8] = 8'h00;
    msg_block[idx][(3 - pos % 4) * 8 +: 8] = 8'h80;
    idx++;
    if (idx > 14) begin
      while (idx < 16) msg_block[idx++] = '0;
      compress();
      idx = 0;
    end
    while (idx < 14) msg_block[idx++] = '0;
    msg_block[14] = bits[63:32];
    msg_block[15] = bits[31:0];
    compress();
    for (int i = 0; i < (hash_mode ? 7 : 8); i++) begin
      digest_q.push_back('{word: chain[i], last: (i == (hash_mode ? 6 : 7))});
    end
    msg_bytes = '0;
    load_iv();
  endfunction

  function automatic void model_word(word_t word, logic [2:0] cnt, logic last);
    int n;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (int i = 0; i < n; i++) absorb_byte(word[31 - 8 * i -: 8]);
    if (last) finish_digest();
  endfunction

  task automatic send_word(word_t word, logic [2:0] cnt, logic last);
    in_valid_i   <= 1'b1;
    data_word_i  <= word;
    byte_count_i <= cnt;
    last_item_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_word(word, cnt, last);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hash_mode = m;
    if (msg_bytes == 64'd0) load_iv();
  endtask

  // one message of nw words, mostly full, then a last word with lcnt bytes
  task automatic send_message(int nw, logic [2:0] lcnt);
    logic [2:0] cnt;
    for (int i = 0; i < nw; i++) begin
      cnt = 3'd4;
      if ($urandom_range(0, 9) == 0) cnt = 3'($urandom_range(0, 7));
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, lcnt, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'h8000_0001, 3'd2, 1'b1);
    send_word(32'hdead_beef, 3'd3, 1'b1);
    // oversized counts act as four bytes
    send_word(32'h1234_5678, 3'd5, 1'b0);
    send_word(32'h9abc_def0, 3'd6, 1'b0);
    send_word(32'h0f0f_0f0f, 3'd7, 1'b1);
    wait_drain();
  endtask

  task automatic test_short_inner_words();
    send_word(32'haabb_ccdd, 3'd1, 1'b0);
    send_word(32'h1122_3344, 3'd3, 1'b0);
    send_word(32'h5566_7788, 3'd0, 1'b0);
    send_word(32'h99aa_bbcc, 3'd2, 1'b1);
    wait_drain();
  endtask

  task automatic test_modes();
    write_mode(ModeSha224);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'h0, 3'd0, 1'b1);
    wait_drain();
    // change mode with a message open, block idle
    send_word(32'h0102_0304, 3'd4, 1'b0);
    send_word(32'h0506_0708, 3'd4, 1'b0);
    wait_drain();
    write_mode(ModeSha256);
    send_word(32'h090a_0b0c, 3'd2, 1'b1);
    wait_drain();
    send_word(32'hcafe_f00d, 3'd4, 1'b0);
    wait_drain();
    write_mode(ModeSha224);
    send_word(32'h0, 3'd4, 1'b1);
    wait_drain();
    write_mode(ModeSha256);
  endtask

  task automatic test_backpressure();
    long_holds++;
    for (int i = 0; i < 4; i++) send_message($urandom_range(0, 3), 3'd4);
    wait_drain();
  endtask

  task automatic test_random_messages();
    int phase_end;
    while (items_sent < 310) begin
      phase_end = items_sent + 80;
      if (phase_end > 310) phase_end = 310;
      while (items_sent < phase_end) begin
        if (items_sent > 260) calm = 1'b1;
        if ($urandom_range(0, 7) == 0) send_message($urandom_range(13, 34), 3'($urandom_range(0, 7)));
        else send_message($urandom_range(0, 16), 3'($urandom_range(0, 7)));
      end
      wait_drain();
      write_mode(1'($urandom_range(0, 1)));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h last %b", digest_word_o,
                                       digest_last_o);
      end else begin
        if (digest_word_o !== digest_q[0].word || digest_last_o !== digest_q[0].last) begin
          mismatches++;
          if (mismatches <= 10) $display("digest mismatch: exp %h/%b got %h/%b",
                                         digest_q[0].word, digest_q[0].last,
                                         digest_word_o, digest_last_o);
        end
        void'(digest_q.pop_front());
      end
    end
  end

  // receiver stall: random short bursts, a long hold when a test asks for one
  initial begin
    int long_seen;
    int hold_left;
    long_seen   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_seen != long_holds) begin
        long_seen = long_holds;
        hold_left = 300;
      end else if (hold_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 5);
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_item_i  = 1'b0;
    items_sent   = 0;
    hash_mode    = ModeSha256;
    msg_bytes    = '0;
    load_iv();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_short_inner_words();
    test_modes();
    test_backpressure();
    test_random_messages();
    wait_drain();
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
